@@ sv/modular_inverse_unit_defines.svh @@
// Assertion macros shared by the modular inverse unit.
`ifndef MODULAR_INVERSE_UNIT_DEFINES_SVH
`define MODULAR_INVERSE_UNIT_DEFINES_SVH

// Clocked check, held off while reset is asserted.
`define MODINV_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked check that also applies during reset.
`define MODINV_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ sv/modinv_pkg.sv @@
// Types and constants for the modular inverse unit.
`default_nettype none

package modinv_pkg;

    localparam int unsigned WIDTH = 32;

    typedef struct packed {
        logic [WIDTH-1:0] value;
        logic [WIDTH-1:0] modulus;
    } t_req;

    typedef struct packed {
        logic             has_inverse;
        logic [WIDTH-1:0] inverse;
        logic [WIDTH-1:0] common_divisor;
    } t_res;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOP,
        ST_DIV,
        ST_FINAL
    } t_state;

endpackage

`default_nettype wire

@@ sv/modinv_div.sv @@
// Shift-subtract divider that also forms quotient times a multiplier.
`default_nettype none

module modinv_div (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [modinv_pkg::WIDTH-1:0] i_dividend,
    input  wire logic [modinv_pkg::WIDTH-1:0] i_divisor,
    input  wire logic [modinv_pkg::WIDTH-1:0] i_mult,
    output logic                              o_done,
    output logic      [modinv_pkg::WIDTH-1:0] o_rem,
    output logic      [modinv_pkg::WIDTH-1:0] o_prod
);

    localparam int unsigned W  = modinv_pkg::WIDTH;
    localparam int unsigned CW = $clog2(W);

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [CW-1:0] r_cnt,  n_cnt;
    logic [W-1:0]  r_rem,  n_rem;
    logic [W-1:0]  r_quo,  n_quo;
    logic [W-1:0]  r_acc,  n_acc;

    logic [W:0]    w_rem_sh;
    logic [W+1:0]  w_diff;
    logic          w_qbit;

    // One quotient bit per cycle, MSB first; the product accumulates by Horner's rule.
    always_comb begin
        w_rem_sh = {r_rem, r_quo[W-1]};
        w_diff   = {1'b0, w_rem_sh} - {2'b00, i_divisor};
        w_qbit   = ~w_diff[W+1];

        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_acc  = r_acc;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_quo  = i_dividend;
            n_acc  = '0;
        end else if (r_busy) begin
            n_rem = w_qbit ? w_diff[W-1:0] : w_rem_sh[W-1:0];
            n_quo = {r_quo[W-2:0], 1'b0};
            n_acc = {r_acc[W-2:0], 1'b0} + (w_qbit ? i_mult : '0);
            n_cnt = r_cnt + CW'(1);
            if (r_cnt == CW'(W-1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_acc <= n_acc;
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;
    assign o_prod = r_acc;

endmodule

`default_nettype wire

@@ sv/modular_inverse_unit.sv @@
// A request runs k Euclid steps from acceptance to result (k <= 47 at 32 bits).
// Each Euclid step runs the bit-serial divider (one bit per cycle).
// Requests are taken one at a time; o_in_ready is high only in idle.
// A finished result sits in the output register while the next request is taken.
// Reset (synchronous, active low) clears the sequencer and drops any pending result.
// Top level of the modular inverse unit.
`default_nettype none

module modular_inverse_unit (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire modinv_pkg::t_req i_in_req,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output modinv_pkg::t_res      o_out_res
);

`include "modular_inverse_unit_defines.svh"

    localparam int unsigned W = modinv_pkg::WIDTH;

    modinv_pkg::t_state r_state, n_state;

    // Remainder pair, Bezout magnitude pair, parity of the remainder index.
    logic [W-1:0] r_r0, r_r1;
    logic [W-1:0] r_s0, r_s1;
    logic         r_odd;
    logic [W-1:0] r_m;

    logic             r_out_valid;
    modinv_pkg::t_res r_out;

    logic         w_accept;
    logic         w_div_start;
    logic         w_out_load;
    logic         w_div_done;
    logic [W-1:0] w_div_rem;
    logic [W-1:0] w_div_prod;

    logic         w_ok;
    logic [W-1:0] w_mag;
    logic [W-1:0] w_inv;

    // Shared divider: r0 / r1, plus quotient times s1 for the coefficient update.
    modinv_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_r0),
        .i_divisor  (r_r1),
        .i_mult     (r_s1),
        .o_done     (w_div_done),
        .o_rem      (w_div_rem),
        .o_prod     (w_div_prod)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            modinv_pkg::ST_IDLE: begin
                if (i_in_valid) n_state = modinv_pkg::ST_LOOP;
            end
            modinv_pkg::ST_LOOP: begin
                // Stop when the remainder hits zero; r0 then holds the gcd.
                if (r_r1 == '0) n_state = modinv_pkg::ST_FINAL;
                else            n_state = modinv_pkg::ST_DIV;
            end
            modinv_pkg::ST_DIV: begin
                if (w_div_done) n_state = modinv_pkg::ST_LOOP;
            end
            modinv_pkg::ST_FINAL: begin
                // Hold until the output register is free.
                if (!r_out_valid || i_out_ready) n_state = modinv_pkg::ST_IDLE;
            end
            default: n_state = modinv_pkg::ST_IDLE;
        endcase
    end

    // Control outputs.
    always_comb begin
        o_in_ready  = 1'b0;
        w_div_start = 1'b0;
        w_out_load  = 1'b0;
        unique case (r_state)
            modinv_pkg::ST_IDLE:  o_in_ready  = 1'b1;
            modinv_pkg::ST_LOOP:  w_div_start = (r_r1 != '0);
            modinv_pkg::ST_DIV:   ;
            modinv_pkg::ST_FINAL: w_out_load  = !r_out_valid || i_out_ready;
            default:              ;
        endcase
    end

    assign w_accept = i_in_valid && o_in_ready;

    // Normalize the coefficient: s0 never exceeds the modulus, so one subtract folds it.
    always_comb begin
        w_ok  = (r_m != '0) && (r_r0 == W'(1));
        w_mag = (r_s0 >= r_m) ? (r_s0 - r_m) : r_s0;
        if (!w_ok)              w_inv = '0;
        else if (!r_odd)        w_inv = w_mag;
        else if (w_mag != '0)   w_inv = r_m - w_mag;
        else                    w_inv = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= modinv_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_out_load)       r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

    // Datapath: load on request, advance one Euclid step per divider completion.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_r0  <= i_in_req.value;
            r_r1  <= i_in_req.modulus;
            r_s0  <= W'(1);
            r_s1  <= '0;
            r_odd <= 1'b0;
            r_m   <= i_in_req.modulus;
        end else if (r_state == modinv_pkg::ST_DIV && w_div_done) begin
            r_r0  <= r_r1;
            r_r1  <= w_div_rem;
            r_s0  <= r_s1;
            r_s1  <= r_s0 + w_div_prod;
            r_odd <= ~r_odd;
        end
        if (w_out_load) begin
            r_out.has_inverse    <= w_ok;
            r_out.inverse        <= w_inv;
            r_out.common_divisor <= r_r0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_out;

    // Divider completions only arrive while the sequencer waits for them.
    `MODINV_ASSERT(a_done_in_div, w_div_done |-> (r_state == modinv_pkg::ST_DIV), "divider done outside wait")
    // An accepted request always starts the loop.
    `MODINV_ASSERT(a_accept_loop, w_accept |=> (r_state == modinv_pkg::ST_LOOP), "request did not start loop")
    // A reported inverse lies below the modulus.
    `MODINV_ASSERT(a_inv_range, (r_state == modinv_pkg::ST_FINAL && w_ok) |-> (w_inv < r_m), "inverse out of range")

endmodule

`default_nettype wire
